FILE: rtl/core/jse_pkg.sv
// Package for the JSON string escaper with UTF-8 check.
// Holds the command format passed from the front end to the back end, and helpers.
// No dependencies.
package jse_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharQuote  = 8'h22;
  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharLowerU = 8'h75;
  localparam logic [7:0] CharZero   = 8'h30;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_PLAIN,
    KIND_ESC2,
    KIND_UNI,
    KIND_SEQ,
    KIND_CLOSE,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    logic       open;
    kind_e      kind;
    logic [1:0] seq_len;
    logic [7:0] data;
    logic [7:0] held0;
    logic [7:0] held1;
    logic [7:0] held2;
  } cmd_t;

  function automatic logic [2:0] cmd_len(cmd_t c);
    logic [2:0] base;
    case (c.kind)
      KIND_PLAIN: base = 3'd1;
      KIND_ESC2:  base = 3'd2;
      KIND_UNI:   base = 3'd6;
      KIND_SEQ:   base = {1'b0, c.seq_len} + 3'd1;
      KIND_CLOSE: base = 3'd1;
      KIND_ERR:   base = 3'd1;
      default:    base = 3'd0;
    endcase
    return base + {2'b00, c.open};
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] v);
    logic [7:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0000, v};
    end else begin
      r = 8'h37 + {4'b0000, v};
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/jse_front.sv
// Front end: accepts input bytes, tracks string and UTF-8 state, issues commands.
// Depends on jse_pkg.
module jse_front import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic        in_string_q, in_string_d;
  logic        discarding_q, discarding_d;
  logic [1:0]  pend_q, pend_d;
  logic [1:0]  seq_q, seq_d;
  logic [20:0] cp_q, cp_d;
  logic [7:0]  held_q [3];
  logic        held_wr;
  logic [1:0]  held_idx;
  logic [20:0] cp_add;
  logic [20:0] cp_new;
  logic        cp_ok;
  logic        open;
  logic        fail;
  kind_e       kind;

  always_comb begin
    case (pend_q)
      2'd1:    cp_add = {15'b0, byte_i[5:0]};
      2'd2:    cp_add = {9'b0, byte_i[5:0], 6'b0};
      default: cp_add = {3'b0, byte_i[5:0], 12'b0};
    endcase
    cp_new = cp_q | cp_add;
    case (seq_q)
      2'd1:    cp_ok = cp_new >= 21'h80;
      2'd2:    cp_ok = (cp_new >= 21'h800) && !((cp_new >= 21'hD800) && (cp_new <= 21'hDFFF));
      default: cp_ok = (cp_new >= 21'h10000) && (cp_new <= 21'h10FFFF);
    endcase
  end

  always_comb begin
    in_string_d  = in_string_q;
    discarding_d = discarding_q;
    pend_d       = pend_q;
    seq_d        = seq_q;
    cp_d         = cp_q;
    held_wr      = 1'b0;
    held_idx     = 2'd0;
    open         = 1'b0;
    fail         = 1'b0;
    kind         = KIND_NONE;
    push_o       = 1'b0;
    if (accept_i) begin
      if (discarding_q) begin
        if (byte_i == 8'h00) begin
          discarding_d = 1'b0;
        end
      end else begin
        open        = !in_string_q;
        in_string_d = 1'b1;
        if (pend_q != 2'd0 && in_string_q) begin
          if (byte_i[7:6] != 2'b10) begin
            fail = 1'b1;
          end else begin
            pend_d = pend_q - 2'd1;
            if (pend_d != 2'd0) begin
              cp_d     = cp_new;
              held_wr  = 1'b1;
              held_idx = seq_q - pend_d;
            end else if (!cp_ok) begin
              fail = 1'b1;
            end else begin
              kind  = KIND_SEQ;
              seq_d = 2'd0;
              cp_d  = '0;
            end
          end
        end else begin
          if (open) begin
            pend_d = 2'd0;
            seq_d  = 2'd0;
            cp_d   = '0;
          end
          if (byte_i[7] == 1'b0) begin
            if (byte_i == 8'h00) begin
              kind        = KIND_CLOSE;
              in_string_d = 1'b0;
            end else if (byte_i < 8'h20) begin
              kind = KIND_UNI;
            end else if (byte_i == CharQuote || byte_i == CharBslash) begin
              kind = KIND_ESC2;
            end else begin
              kind = KIND_PLAIN;
            end
          end else if ((byte_i & 8'hE0) == 8'hC0) begin
            seq_d   = 2'd1;
            pend_d  = 2'd1;
            cp_d    = {10'b0, byte_i[4:0], 6'b0};
            held_wr = 1'b1;
          end else if ((byte_i & 8'hF0) == 8'hE0) begin
            seq_d   = 2'd2;
            pend_d  = 2'd2;
            cp_d    = {5'b0, byte_i[3:0], 12'b0};
            held_wr = 1'b1;
          end else if ((byte_i & 8'hF8) == 8'hF0) begin
            seq_d   = 2'd3;
            pend_d  = 2'd3;
            cp_d    = {byte_i[2:0], 18'b0};
            held_wr = 1'b1;
          end else begin
            fail = 1'b1;
          end
        end
        if (fail) begin
          kind         = KIND_ERR;
          in_string_d  = 1'b0;
          pend_d       = 2'd0;
          seq_d        = 2'd0;
          cp_d         = '0;
          held_wr      = 1'b0;
          discarding_d = byte_i != 8'h00;
        end
        push_o = open || (kind != KIND_NONE);
      end
    end
  end

  always_comb begin
    cmd_o.open    = open;
    cmd_o.kind    = kind;
    cmd_o.seq_len = seq_q;
    cmd_o.data    = byte_i;
    cmd_o.held0   = held_q[0];
    cmd_o.held1   = held_q[1];
    cmd_o.held2   = held_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q  <= 1'b0;
      discarding_q <= 1'b0;
      pend_q       <= 2'd0;
      seq_q        <= 2'd0;
      cp_q         <= '0;
    end else begin
      in_string_q  <= in_string_d;
      discarding_q <= discarding_d;
      pend_q       <= pend_d;
      seq_q        <= seq_d;
      cp_q         <= cp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (held_wr) begin
      held_q[held_idx] <= byte_i;
    end
  end

  a_disc_not_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    discarding_q |-> (!in_string_q && pend_q == 2'd0))
    else $error("Discarding while a string is open.");

  a_pend_le_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= seq_q)
    else $error("More continuation bytes pending than the sequence holds.");

  a_err_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o && kind == KIND_ERR) |=> (!in_string_q && pend_q == 2'd0))
    else $error("An error did not close the string.");

endmodule

FILE: rtl/core/jse_queue.sv
// Command queue between the front end and the back end.
// Depends on jse_pkg.
module jse_queue import jse_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = cnt_q == QueueCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && full_o) |-> pop_i)
    else $error("Push into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("Pop from an empty queue.");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("Queue count beyond the depth.");

endmodule

FILE: rtl/core/jse_back.sv
// Back end: expands each queued command into output bytes behind an output register.
// Depends on jse_pkg.
module jse_back import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       error_o
);

  logic [2:0] sub_q, sub_d;
  logic       ov_q, ov_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic [2:0] total;
  logic [2:0] pos;
  logic       fire;

  assign total = cmd_len(cmd_i);
  assign pos   = sub_q - {2'b00, cmd_i.open};
  assign fire  = valid_i && (!ov_q || out_ready_i);
  assign pop_o = fire && (sub_q == total - 3'd1);

  always_comb begin
    byte_d = 8'h00;
    last_d = 1'b0;
    err_d  = 1'b0;
    if (cmd_i.open && sub_q == 3'd0) begin
      byte_d = CharQuote;
    end else begin
      case (cmd_i.kind)
        KIND_PLAIN: byte_d = cmd_i.data;
        KIND_ESC2:  byte_d = (pos == 3'd0) ? CharBslash : cmd_i.data;
        KIND_UNI: begin
          case (pos)
            3'd0:    byte_d = CharBslash;
            3'd1:    byte_d = CharLowerU;
            3'd2:    byte_d = CharZero;
            3'd3:    byte_d = CharZero;
            3'd4:    byte_d = nibble_char(cmd_i.data[7:4]);
            default: byte_d = nibble_char(cmd_i.data[3:0]);
          endcase
        end
        KIND_SEQ: begin
          if (pos == {1'b0, cmd_i.seq_len}) begin
            byte_d = cmd_i.data;
          end else begin
            case (pos[1:0])
              2'd0:    byte_d = cmd_i.held0;
              2'd1:    byte_d = cmd_i.held1;
              default: byte_d = cmd_i.held2;
            endcase
          end
        end
        KIND_CLOSE: begin
          byte_d = CharQuote;
          last_d = 1'b1;
        end
        KIND_ERR: begin
          last_d = 1'b1;
          err_d  = 1'b1;
        end
        default: byte_d = 8'h00;
      endcase
    end
  end

  always_comb begin
    ov_d  = ov_q;
    sub_d = sub_q;
    if (fire) begin
      ov_d  = 1'b1;
      sub_d = pop_o ? 3'd0 : sub_q + 3'd1;
    end else if (out_ready_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q  <= 1'b0;
      sub_q <= 3'd0;
    end else begin
      ov_q  <= ov_d;
      sub_q <= sub_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      byte_q <= byte_d;
      last_q <= last_d;
      err_q  <= err_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

  a_sub_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (sub_q < total))
    else $error("Byte index beyond the command length.");

  a_sub_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_i |-> (sub_q == 3'd0))
    else $error("Byte index left over with an empty queue.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(out_byte_o) && $stable(last_o) && $stable(error_o)))
    else $error("Output transaction changed while waiting.");

endmodule

FILE: rtl/core/json_string_escaper_utf8_check_unit.sv
// Top level of the JSON string escaper with UTF-8 check.
// Depends on jse_pkg, jse_front, jse_queue and jse_back.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      in_valid_i / in_ready_o   in_byte_i
//   out      output     out_valid_o / out_ready_i out_byte_o, last_o, error_o
//
// An input byte is taken each cycle while the four-entry command queue has room.
// The back end sends one output byte per cycle while out_ready_i is high; an input
// byte yields none to seven output bytes, and the output register sets that pace.
// Reset clears string state, the queue and the output valid flag at once.
// A stall on the output fills the queue and then holds off input.
module json_string_escaper_utf8_check_unit import jse_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       error_o
);

  logic accept;
  logic push;
  logic full;
  logic q_valid;
  logic pop;
  cmd_t cmd_in;
  cmd_t cmd_head;

  assign in_ready_o = !full;
  assign accept     = in_valid_i && in_ready_o;

  jse_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (in_byte_i),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  jse_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (cmd_head),
    .pop_i   (pop)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

endmodule
